@@ rtl/core/rp2y_pkg.sv @@
`default_nettype none
package rp2y_pkg;

	localparam logic [15:0] K_YR = 16'd19595;
	localparam logic [15:0] K_YG = 16'd38470;
	localparam logic [15:0] K_YB = 16'd7471;
	localparam logic [15:0] K_U  = 16'd36962;
	localparam logic [15:0] K_V  = 16'd46727;

	localparam logic signed [25:0] CHROMA_OFFSET = 26'sd8388608;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] r0;
		logic [7:0] b0;
		logic [7:0] r1;
		logic [7:0] b1;
		logic       last;
	} luma_item_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
		logic       last;
	} yuv_item_t;

endpackage
`default_nettype wire

@@ rtl/core/rp2y_luma.sv @@
`default_nettype none
module rp2y_luma (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  rp2y_pkg::pix_t           pix0,
	input  rp2y_pkg::pix_t           pix1,
	input  wire                      last,
	output logic                     out_valid,
	input  wire                      out_ready,
	output rp2y_pkg::luma_item_t     out_item
);
	import rp2y_pkg::*;

	logic        v_s1, v_s2;
	logic        en1, en2;
	logic [23:0] pr0_s1, pg0_s1, pb0_s1, pr1_s1, pg1_s1, pb1_s1;
	logic [7:0]  r0_s1, b0_s1, r1_s1, b1_s1;
	logic        last_s1;
	luma_item_t  item_s2;
	logic [23:0] sum0, sum1;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pr0_s1  <= 24'(pix0.r) * 24'(K_YR);
			pg0_s1  <= 24'(pix0.g) * 24'(K_YG);
			pb0_s1  <= 24'(pix0.b) * 24'(K_YB);
			pr1_s1  <= 24'(pix1.r) * 24'(K_YR);
			pg1_s1  <= 24'(pix1.g) * 24'(K_YG);
			pb1_s1  <= 24'(pix1.b) * 24'(K_YB);
			r0_s1   <= pix0.r;
			b0_s1   <= pix0.b;
			r1_s1   <= pix1.r;
			b1_s1   <= pix1.b;
			last_s1 <= last;
		end
	end

	assign sum0 = pr0_s1 + pg0_s1 + pb0_s1;
	assign sum1 = pr1_s1 + pg1_s1 + pb1_s1;

	always_ff @(posedge clk) begin
		if (en2) begin
			item_s2.y0   <= sum0[23:16];
			item_s2.y1   <= sum1[23:16];
			item_s2.r0   <= r0_s1;
			item_s2.b0   <= b0_s1;
			item_s2.r1   <= r1_s1;
			item_s2.b1   <= b1_s1;
			item_s2.last <= last_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2))
		else $error("luma: input blocked with a free stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("luma: accepted item lost in stage 1");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en2) |=> v_s2)
		else $error("luma: item lost between stage 1 and stage 2");

endmodule
`default_nettype wire

@@ rtl/core/rp2y_chroma.sv @@
`default_nettype none
module rp2y_chroma (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  rp2y_pkg::luma_item_t     in_item,
	output logic                     out_valid,
	input  wire                      out_ready,
	output rp2y_pkg::yuv_item_t      out_item
);
	import rp2y_pkg::*;

	function automatic logic signed [9:0] trunc_frac(input logic signed [24:0] p);
		logic signed [25:0] acc;
		logic [9:0]         q;
		acc = 26'(p) + CHROMA_OFFSET;
		q   = acc[25:16] + {9'd0, acc[25] && (acc[15:0] != 16'd0)};
		return $signed(q);
	endfunction

	function automatic logic [7:0] avg_clip(input logic signed [9:0] a,
		input logic signed [9:0] b);
		logic signed [10:0] s;
		logic [9:0]         h;
		logic signed [9:0]  hs;
		s  = 11'(a) + 11'(b);
		h  = s[10:1] + {9'd0, s[10] && s[0]};
		hs = $signed(h);
		if (hs < 10'sd0) begin
			return 8'd0;
		end else if (hs > 10'sd255) begin
			return 8'd255;
		end
		return h[7:0];
	endfunction

	logic                    v_s3, v_s4, v_s5;
	logic                    en3, en4, en5;
	logic signed [8:0]       du0, du1, dv0, dv1;
	logic signed [24:0]      pu0_s3, pu1_s3, pv0_s3, pv1_s3;
	logic [7:0]              y0_s3, y1_s3, y0_s4, y1_s4;
	logic                    last_s3, last_s4;
	logic signed [9:0]       cu0_s4, cu1_s4, cv0_s4, cv1_s4;
	yuv_item_t               item_s5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= in_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	assign du0 = $signed({1'b0, in_item.b0}) - $signed({1'b0, in_item.y0});
	assign du1 = $signed({1'b0, in_item.b1}) - $signed({1'b0, in_item.y1});
	assign dv0 = $signed({1'b0, in_item.r0}) - $signed({1'b0, in_item.y0});
	assign dv1 = $signed({1'b0, in_item.r1}) - $signed({1'b0, in_item.y1});

	always_ff @(posedge clk) begin
		if (en3) begin
			pu0_s3  <= 25'(du0) * 25'($signed({1'b0, K_U}));
			pu1_s3  <= 25'(du1) * 25'($signed({1'b0, K_U}));
			pv0_s3  <= 25'(dv0) * 25'($signed({1'b0, K_V}));
			pv1_s3  <= 25'(dv1) * 25'($signed({1'b0, K_V}));
			y0_s3   <= in_item.y0;
			y1_s3   <= in_item.y1;
			last_s3 <= in_item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			cu0_s4  <= trunc_frac(pu0_s3);
			cu1_s4  <= trunc_frac(pu1_s3);
			cv0_s4  <= trunc_frac(pv0_s3);
			cv1_s4  <= trunc_frac(pv1_s3);
			y0_s4   <= y0_s3;
			y1_s4   <= y1_s3;
			last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			item_s5.y0   <= y0_s4;
			item_s5.u    <= avg_clip(cu0_s4, cu1_s4);
			item_s5.y1   <= y1_s4;
			item_s5.v    <= avg_clip(cv0_s4, cv1_s4);
			item_s5.last <= last_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_item  = item_s5;

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s3 && v_s4 && v_s5))
		else $error("chroma: input blocked with a free stage");

	a_chroma_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (cu0_s4 > -10'sd64 && cu0_s4 < 10'sd320
			&& cv1_s4 > -10'sd64 && cv1_s4 < 10'sd320))
		else $error("chroma: per-pixel chroma out of expected range");

	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en4) |=> v_s4)
		else $error("chroma: item lost between stage 3 and stage 4");

endmodule
`default_nettype wire

@@ rtl/core/rgb_pair_to_yuv422.sv @@
`default_nettype none
// RGB24 pixel pair to packed 4:2:2 (Y0 U Y1 V), BT.601 weights with 16-bit
// fraction coefficients. Takes one pair per clock while the output is
// taken; two stages form the luma (products, then sum), three form the
// chroma (difference times weight, offset and truncate, pair average and
// clip). Every stage holds its own valid bit, so bubbles collapse under
// backpressure; tready of the input falls only when all five stages hold
// items and the output is not taken.
// tlast marks the last pair of a frame and passes through unchanged.
module rgb_pair_to_yuv422 (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// red_first, green_first, blue_first, red_second, green_second, blue_second
	input  wire  [47:0] s_axis_tdata,
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// luma_first, chroma_blue, luma_second, chroma_red
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import rp2y_pkg::*;

	pix_t       pix0, pix1;
	luma_item_t luma_item;
	logic       luma_valid, chroma_ready;
	yuv_item_t  yuv_item;

	assign pix0.r = s_axis_tdata[7:0];
	assign pix0.g = s_axis_tdata[15:8];
	assign pix0.b = s_axis_tdata[23:16];
	assign pix1.r = s_axis_tdata[31:24];
	assign pix1.g = s_axis_tdata[39:32];
	assign pix1.b = s_axis_tdata[47:40];

	rp2y_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pix0      (pix0),
		.pix1      (pix1),
		.last      (s_axis_tlast),
		.out_valid (luma_valid),
		.out_ready (chroma_ready),
		.out_item  (luma_item)
	);

	rp2y_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (luma_valid),
		.in_ready  (chroma_ready),
		.in_item   (luma_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (yuv_item)
	);

	assign m_axis_tdata = {yuv_item.v, yuv_item.y1, yuv_item.u, yuv_item.y0};
	assign m_axis_tlast = yuv_item.last;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint W_YR = 19595;
	localparam longint W_YG = 38470;
	localparam longint W_YB = 7471;
	localparam longint W_U  = 36962;
	localparam longint W_V  = 46727;
	localparam longint CHROMA_BIAS = 128 << 16;
	localparam int RANDOM_PAIRS = 1350;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_OFF_AT = 400;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct {
		logic [7:0] r0;
		logic [7:0] g0;
		logic [7:0] b0;
		logic [7:0] r1;
		logic [7:0] g1;
		logic [7:0] b1;
		logic       fe;
	} rgb_pair_t;

	typedef struct {
		logic [7:0] y0;
		logic [7:0] u;
		logic [7:0] y1;
		logic [7:0] v;
		logic       fe;
	} yuv_group_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	rgb_pair_t  pending_pairs[$];
	yuv_group_t expected_yuv[$];
	rgb_pair_t  pair_on_bus;
	int         send_gap = 0;
	int         stall_left = 0;
	int         groups_seen = 0;
	int         mismatches = 0;
	int         idle_cycles = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	bit         held_off = 1'b0;
	bit         draining = 1'b0;

	rgb_pair_to_yuv422 dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	function automatic longint bt601_luma(longint r, longint g, longint b);
		return (W_YR * r + W_YG * g + W_YB * b) >>> 16;
	endfunction

	// signed division truncates toward zero
	function automatic longint chroma_term(longint c, longint y, longint k);
		longint acc;
		acc = (c - y) * k + CHROMA_BIAS;
		return acc / 65536;
	endfunction

	function automatic logic [7:0] clip_to_byte(longint x);
		if (x < 0)
			return 8'd0;
		if (x > 255)
			return 8'd255;
		return x[7:0];
	endfunction

	function automatic yuv_group_t predict_yuv(rgb_pair_t p);
		yuv_group_t g;
		longint y0, y1, u, v;
		y0 = bt601_luma(p.r0, p.g0, p.b0);
		y1 = bt601_luma(p.r1, p.g1, p.b1);
		u = (chroma_term(p.b0, y0, W_U) + chroma_term(p.b1, y1, W_U)) / 2;
		v = (chroma_term(p.r0, y0, W_V) + chroma_term(p.r1, y1, W_V)) / 2;
		g.y0 = clip_to_byte(y0);
		g.u = clip_to_byte(u);
		g.y1 = clip_to_byte(y1);
		g.v = clip_to_byte(v);
		g.fe = p.fe;
		return g;
	endfunction

	function automatic int draw_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] draw_level(int kind);
		case (kind)
			0: begin
				return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			1: begin
				return $urandom_range(0, 1) ? 8'($urandom_range(252, 255))
					: 8'($urandom_range(0, 3));
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	task automatic add_pair(logic [7:0] r0, logic [7:0] g0, logic [7:0] b0,
			logic [7:0] r1, logic [7:0] g1, logic [7:0] b1, logic fe);
		rgb_pair_t p;
		p.r0 = r0;
		p.g0 = g0;
		p.b0 = b0;
		p.r1 = r1;
		p.g1 = g1;
		p.b1 = b1;
		p.fe = fe;
		pending_pairs.push_back(p);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_yuv.push_back(predict_yuv(pair_on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					pair_on_bus = pending_pairs.pop_front();
					s_axis_tdata <= {pair_on_bus.b1, pair_on_bus.g1, pair_on_bus.r1,
						pair_on_bus.b0, pair_on_bus.g0, pair_on_bus.r0};
					s_axis_tlast <= pair_on_bus.fe;
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(0, 149) == 0)
						tx_calm = ~tx_calm;
					send_gap = draw_gap(tx_calm);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		yuv_group_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				groups_seen++;
				if (expected_yuv.size() == 0) begin
					$error("unexpected item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
					mismatches++;
				end else begin
					want = expected_yuv.pop_front();
					if (m_axis_tdata[7:0] !== want.y0) begin
						$error("luma_first: expected %0d, got %0d", want.y0, m_axis_tdata[7:0]);
						mismatches++;
					end
					if (m_axis_tdata[15:8] !== want.u) begin
						$error("chroma_blue: expected %0d, got %0d", want.u, m_axis_tdata[15:8]);
						mismatches++;
					end
					if (m_axis_tdata[23:16] !== want.y1) begin
						$error("luma_second: expected %0d, got %0d", want.y1,
							m_axis_tdata[23:16]);
						mismatches++;
					end
					if (m_axis_tdata[31:24] !== want.v) begin
						$error("chroma_red: expected %0d, got %0d", want.v, m_axis_tdata[31:24]);
						mismatches++;
					end
					if (m_axis_tlast !== want.fe) begin
						$error("frame_end_out: expected %b, got %b", want.fe, m_axis_tlast);
						mismatches++;
					end
				end
				if ($urandom_range(0, 149) == 0)
					rx_calm = ~rx_calm;
			end
			if (draining) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!held_off && groups_seen >= HOLD_OFF_AT) begin
				// hold off long enough to fill the pipeline and stall the input
				held_off = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
				stall_left = draw_gap(1'b0);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		int kind;
		add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
		add_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0);
		add_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0);
		add_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
		add_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
		add_pair(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
		add_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 1'b0);
		add_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
		add_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0);
		add_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
		add_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
		add_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
		add_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1);
		add_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 1'b0);
		add_pair(8'd1, 8'd0, 8'd254, 8'd254, 8'd255, 8'd1, 1'b0);
		add_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
		add_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
		add_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		add_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) begin
				add_pair(draw_level(0), draw_level(0), draw_level(0),
					draw_level(0), draw_level(0), draw_level(0),
					$urandom_range(0, 15) == 0);
			end else if (kind < 30) begin
				add_pair(draw_level(1), draw_level(1), draw_level(1),
					draw_level(1), draw_level(1), draw_level(1),
					$urandom_range(0, 15) == 0);
			end else if (kind < 40) begin
				pair_on_bus.r0 = draw_level(2);
				pair_on_bus.r1 = draw_level(2);
				add_pair(pair_on_bus.r0, pair_on_bus.r0, pair_on_bus.r0,
					pair_on_bus.r1, pair_on_bus.r1, pair_on_bus.r1,
					$urandom_range(0, 15) == 0);
			end else begin
				add_pair(draw_level(2), draw_level(2), draw_level(2),
					draw_level(2), draw_level(2), draw_level(2),
					$urandom_range(0, 15) == 0);
			end
		end

		@(posedge clk);
		while ((pending_pairs.size() != 0 || s_axis_tvalid || expected_yuv.size() != 0
				|| arst_n !== 1'b1) && idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end

		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
		end else begin
			draining = 1'b1;
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (mismatches == 0 && expected_yuv.size() == 0)
				$display("tb_top passed");
			else
				$display("tb_top failed");
		end
		$finish;
	end

endmodule
